@@ src/xmodem_checksum_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// XMODEM checksum receiver assertion macros
// Clocked assertion wrappers shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH
`define XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define XMCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("xmcr assertion failed");

// next-cycle implication, disabled in reset
`define XMCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("xmcr assertion failed");

`endif

@@ src/xmcr_pkg.sv @@
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Protocol codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package xmcr_pkg;

    // item opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // control characters
    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_CAN = 8'h18;

    // end status codes
    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_CANCELLED = 2'd1;
    localparam logic [1:0] ST_RETRIES   = 2'd2;
    localparam logic [1:0] ST_REJECTED  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_START_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_BYTE_TIMEOUT  = 2'd2;

    localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd10;
    localparam logic [15:0] START_TIMEOUT_RST = 16'd6000;
    localparam logic [15:0] BYTE_TIMEOUT_RST  = 16'd2000;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    typedef struct packed {
        logic [7:0]  retry_limit;
        logic [15:0] start_timeout;
        logic [15:0] byte_timeout;
    } t_cfg;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [6:0] data_index;
        logic       verdict_valid;
        logic       packet_accepted;
        logic       finished;
        logic [1:0] end_status;
    } t_result;

endpackage

@@ src/xmcr_in_if.sv @@
// ----------------------------------------------------------------------------
// XMODEM receiver input channel
// Valid/ready channel carrying one opcode and received byte per item.
// ----------------------------------------------------------------------------
interface xmcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

@@ src/xmcr_out_if.sv @@
// ----------------------------------------------------------------------------
// XMODEM receiver result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface xmcr_out_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic       verdict_valid;
    logic       packet_accepted;
    logic       finished;
    logic [1:0] end_status;

    modport source (
        output valid, input ready,
        output send_valid, output send_byte, output data_valid, output data_byte,
        output data_index, output verdict_valid, output packet_accepted,
        output finished, output end_status
    );
    modport sink (
        input valid, output ready,
        input send_valid, input send_byte, input data_valid, input data_byte,
        input data_index, input verdict_valid, input packet_accepted,
        input finished, input end_status
    );
endinterface

@@ src/xmodem_checksum_receiver.sv @@
// ----------------------------------------------------------------------------
// XMODEM checksum receiver
// Receiving side of XMODEM (checksum mode) as an item-per-cycle engine.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one item per handshake: opcode 0 starts a transfer,
//   1 delivers a received byte, 2 is a timer tick. o_result returns exactly
//   one result item per input item: reply byte to send (NAK/ACK), tentative
//   payload byte with its index, packet verdict and end of transfer.
//   Registers (retry limit, start and byte timeouts) are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight.
//   An item is held in the input register, processed combinationally and its
//   result offered from the result register. Throughput is one item per clock
//   while results are taken; the only sequential dependency is the transfer
//   state update, which completes in the same cycle.
//   If the result is not taken, the result register holds it and one more
//   item waits in the input register; then i_item.ready drops.
//   Reset (synchronous, i_rst_n low) empties both registers, returns the
//   transfer to idle and loads the register defaults 10 / 6000 / 2000.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver
    import xmcr_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    xmcr_in_if.sink               i_item,
    xmcr_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "xmodem_checksum_receiver_assert.svh"

    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    t_cfg       cfg;
    t_result    step_res;
    logic       adv;
    logic       in_take;

    assign adv     = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_take = i_item.valid && i_item.ready;
    assign i_item.ready = !r_in_valid || adv;

    xmcr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    xmcr_fsm #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_opcode  (r_in_op),
        .i_rx_byte (r_in_byte),
        .i_cfg     (cfg),
        .o_result  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_item.opcode;
            r_in_byte <= i_item.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.send_valid      = r_out.send_valid;
    assign o_result.send_byte       = r_out.send_byte;
    assign o_result.data_valid      = r_out.data_valid;
    assign o_result.data_byte       = r_out.data_byte;
    assign o_result.data_index      = r_out.data_index;
    assign o_result.verdict_valid   = r_out.verdict_valid;
    assign o_result.packet_accepted = r_out.packet_accepted;
    assign o_result.finished        = r_out.finished;
    assign o_result.end_status      = r_out.end_status;

    // a verdict always carries a reply byte
    `XMCR_ASSERT_NOW(a_verdict_sends, i_clk, i_rst_n,
        r_out_valid && r_out.verdict_valid, r_out.send_valid)
    // accepted packet is answered with ACK
    `XMCR_ASSERT_NOW(a_accept_ack, i_clk, i_rst_n,
        r_out_valid && r_out.packet_accepted,
        r_out.verdict_valid && r_out.send_byte == C_ACK)
    // payload slots never judge or end the transfer
    `XMCR_ASSERT_NOW(a_data_alone, i_clk, i_rst_n,
        r_out_valid && r_out.data_valid, !r_out.verdict_valid && !r_out.finished)
    // a waiting item is kept while the result side stalls
    `XMCR_ASSERT_NEXT(a_hold_pending, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_result.ready,
        r_in_valid && r_out_valid)

endmodule

@@ src/xmcr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// XMODEM receiver configuration registers
// Retry limit and the two timeout values, write-only.
// ----------------------------------------------------------------------------
module xmcr_cfg_regs
    import xmcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit   <= RETRY_LIMIT_RST;
            r_cfg.start_timeout <= START_TIMEOUT_RST;
            r_cfg.byte_timeout  <= BYTE_TIMEOUT_RST;
        end else if (i_we) begin
            case (i_idx)
                CFG_RETRY_LIMIT:   r_cfg.retry_limit   <= i_data[7:0];
                CFG_START_TIMEOUT: r_cfg.start_timeout <= i_data;
                CFG_BYTE_TIMEOUT:  r_cfg.byte_timeout  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/xmcr_fsm.sv @@
// ----------------------------------------------------------------------------
// XMODEM receiver protocol engine
// Transfer state and per-item next-state / result logic.
// ----------------------------------------------------------------------------
module xmcr_fsm
    import xmcr_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int SLOT_W = $clog2(BLOCK_BYTES + 3);
    localparam int IDX_W  = SLOT_W + 7;
    localparam logic [SLOT_W-1:0] SLOT_CSUM = SLOT_W'(BLOCK_BYTES + 2);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_PACKET,
        PH_BETWEEN
    } t_phase;

    t_phase             r_phase,  n_phase;
    logic [SLOT_W-1:0]  r_slot,   n_slot;
    logic [7:0]         r_sum,    n_sum;
    logic [7:0]         r_expect, n_expect;
    logic [7:0]         r_blk,    n_blk;
    logic [7:0]         r_cmp,    n_cmp;
    logic               r_tmo,    n_tmo;
    logic [7:0]         r_retry,  n_retry;
    logic [15:0]        r_idle,   n_idle;
    logic               r_lrej,   n_lrej;

    t_result            res;
    logic [15:0]        tick_inc;
    logic [15:0]        tick_lim;
    logic               tick_out;
    logic [7:0]         retry_inc;
    logic               abandon;
    logic               retry_en;
    logic               fill_en;
    logic               fill_timed;
    logic [7:0]         fill_val;
    logic               pkt_ok;
    logic [IDX_W-1:0]   idx_full;

    assign tick_inc  = r_idle + 16'd1;
    assign tick_lim  = (r_phase == PH_START) ? i_cfg.start_timeout : i_cfg.byte_timeout;
    assign tick_out  = !(tick_inc < tick_lim);
    assign retry_inc = r_retry + 8'd1;
    assign abandon   = !(retry_inc < i_cfg.retry_limit);
    assign idx_full  = {7'd0, r_slot} - IDX_W'(2);
    assign fill_val  = (i_opcode == OP_BYTE) ? i_rx_byte : 8'd0;
    assign fill_timed = (i_opcode == OP_TICK);
    // slot timeout of this item counts against the packet too
    assign pkt_ok = !(r_tmo || fill_timed) && (r_blk == r_expect)
                    && (r_cmp == ~r_expect) && (r_sum == fill_val);

    always_comb begin
        n_phase  = r_phase;
        n_slot   = r_slot;
        n_sum    = r_sum;
        n_expect = r_expect;
        n_blk    = r_blk;
        n_cmp    = r_cmp;
        n_tmo    = r_tmo;
        n_retry  = r_retry;
        n_idle   = r_idle;
        n_lrej   = r_lrej;
        res      = '0;
        retry_en = 1'b0;
        fill_en  = 1'b0;

        if (i_en) begin
            if (i_opcode == OP_START) begin
                n_phase  = PH_START;
                n_retry  = 8'd0;
                n_idle   = 16'd0;
                n_expect = 8'd1;
                n_lrej   = 1'b0;
                res.send_valid = 1'b1;
                res.send_byte  = C_NAK;
            end else if (i_opcode == OP_TICK && r_phase != PH_IDLE) begin
                n_idle = tick_inc;
                if (tick_out) begin
                    n_idle = 16'd0;
                    if (r_phase == PH_PACKET) begin
                        fill_en = 1'b1;
                    end else begin
                        retry_en = 1'b1;
                        if (r_phase == PH_START && !abandon) begin
                            res.send_valid = 1'b1;
                            res.send_byte  = C_NAK;
                        end
                    end
                end
            end else if (i_opcode == OP_BYTE) begin
                case (r_phase)
                    PH_PACKET: fill_en = 1'b1;
                    PH_START: begin
                        if (i_rx_byte == C_SOH) begin
                            n_phase = PH_PACKET;
                            n_slot  = '0;
                            n_sum   = 8'd0;
                            n_blk   = 8'd0;
                            n_cmp   = 8'd0;
                            n_tmo   = 1'b0;
                            n_idle  = 16'd0;
                        end else if (i_rx_byte == C_CAN) begin
                            n_phase = PH_IDLE;
                            res.finished   = 1'b1;
                            res.end_status = ST_CANCELLED;
                        end else begin
                            retry_en = 1'b1;
                            if (!abandon) begin
                                res.send_valid = 1'b1;
                                res.send_byte  = C_NAK;
                            end
                        end
                    end
                    PH_BETWEEN: begin
                        if (i_rx_byte == C_SOH) begin
                            n_retry = 8'd0;
                            n_phase = PH_PACKET;
                            n_slot  = '0;
                            n_sum   = 8'd0;
                            n_blk   = 8'd0;
                            n_cmp   = 8'd0;
                            n_tmo   = 1'b0;
                            n_idle  = 16'd0;
                        end else if (i_rx_byte == C_EOT) begin
                            n_retry = 8'd0;
                            n_phase = PH_IDLE;
                            res.send_valid = 1'b1;
                            res.send_byte  = C_ACK;
                            res.finished   = 1'b1;
                            res.end_status = r_lrej ? ST_REJECTED : ST_SUCCESS;
                        end else begin
                            retry_en = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if (fill_en) begin
                n_idle = 16'd0;
                if (fill_timed) begin
                    n_tmo = 1'b1;
                end
                if (r_slot == '0) begin
                    n_blk  = fill_val;
                    n_slot = r_slot + 1'b1;
                end else if (r_slot == SLOT_W'(1)) begin
                    n_cmp  = fill_val;
                    n_slot = r_slot + 1'b1;
                end else if (r_slot < SLOT_CSUM) begin
                    n_sum  = r_sum + fill_val;
                    n_slot = r_slot + 1'b1;
                    res.data_valid = 1'b1;
                    res.data_byte  = fill_val;
                    res.data_index = idx_full[6:0];
                end else begin
                    // checksum slot: judge the packet
                    res.verdict_valid = 1'b1;
                    res.send_valid    = 1'b1;
                    n_phase = PH_BETWEEN;
                    if (pkt_ok) begin
                        res.packet_accepted = 1'b1;
                        res.send_byte       = C_ACK;
                        n_retry  = 8'd0;
                        n_expect = r_expect + 8'd1;
                        n_lrej   = 1'b0;
                    end else begin
                        res.send_byte = C_NAK;
                        n_lrej   = 1'b1;
                        retry_en = 1'b1;
                    end
                end
            end

            if (retry_en) begin
                n_retry = retry_inc;
                n_idle  = 16'd0;
                if (abandon) begin
                    n_phase = PH_IDLE;
                    res.finished   = 1'b1;
                    res.end_status = ST_RETRIES;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_slot   <= '0;
            r_sum    <= 8'd0;
            r_expect <= 8'd1;
            r_blk    <= 8'd0;
            r_cmp    <= 8'd0;
            r_tmo    <= 1'b0;
            r_retry  <= 8'd0;
            r_idle   <= 16'd0;
            r_lrej   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_slot   <= n_slot;
            r_sum    <= n_sum;
            r_expect <= n_expect;
            r_blk    <= n_blk;
            r_cmp    <= n_cmp;
            r_tmo    <= n_tmo;
            r_retry  <= n_retry;
            r_idle   <= n_idle;
            r_lrej   <= n_lrej;
        end
    end

    assign o_result = res;

endmodule

@@ tb/tb_xmodem_checksum_receiver.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XMODEM checksum receiver testbench
// Drives start commands, received bytes and timer ticks through the item
// channel and predicts every result item cycle-free. Covers the start wait,
// packets with clean and damaged contents, slot and wait timeouts, retry
// exhaustion, cancel and end of transfer, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_xmodem_checksum_receiver;
    import xmcr_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int BLOCK_BYTES = 128;
    localparam int STALL_LIMIT = 2000;

    // opcode 3 is reserved and must be ignored
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef enum logic [2:0] {PH_IDLE, PH_START, PH_PACKET, PH_BETWEEN} t_xfer_phase;
    typedef enum {FLT_NONE, FLT_SUM, FLT_BLOCK, FLT_CMP, FLT_TIMEOUT, FLT_ABORT} t_pkt_fault;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    xmcr_in_if  item_if ();
    xmcr_out_if result_if ();

    xmodem_checksum_receiver i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predicted receiver state and registers
    t_xfer_phase ph          = PH_IDLE;
    int          slot        = 0;
    logic [7:0]  sum_acc     = '0;
    logic [7:0]  exp_block   = 8'd1;
    logic [7:0]  got_blk     = '0;
    logic [7:0]  got_cmp     = '0;
    logic        slot_bad    = 1'b0;
    logic [7:0]  retries     = '0;
    logic [15:0] tick_count  = '0;
    logic        last_rej    = 1'b0;
    logic [7:0]  lim_retry   = RETRY_LIMIT_RST;
    logic [15:0] lim_start   = START_TIMEOUT_RST;
    logic [15:0] lim_byte    = BYTE_TIMEOUT_RST;

    t_result     due_results[$];
    int          errors      = 0;
    int          live_items  = 0;
    int          hold_cycles = 0;
    int          stall_count = 0;
    logic        quiet       = 1'b0;

    function automatic void open_packet();
        ph         = PH_PACKET;
        slot       = 0;
        sum_acc    = '0;
        got_blk    = '0;
        got_cmp    = '0;
        slot_bad   = 1'b0;
        tick_count = '0;
    endfunction

    // one item through the receiver: returns its result and moves the state on
    function automatic t_result advance_receiver(input logic [1:0] op, input logic [7:0] b);
        t_result    r;
        logic       do_fill;
        logic       do_retry;
        logic       nak_retry;
        logic       ok;
        logic [7:0] v;
        r         = '0;
        do_fill   = 1'b0;
        do_retry  = 1'b0;
        nak_retry = 1'b0;
        v         = b;
        if (op == OP_START) begin
            ph         = PH_START;
            retries    = '0;
            tick_count = '0;
            exp_block  = 8'd1;
            last_rej   = 1'b0;
            r.send_valid = 1'b1;
            r.send_byte  = C_NAK;
            return r;
        end
        if (op == OP_NONE || ph == PH_IDLE) return r;

        if (op == OP_TICK) begin
            tick_count = tick_count + 16'd1;
            if (tick_count < ((ph == PH_START) ? lim_start : lim_byte)) return r;
            tick_count = '0;
            if (ph == PH_PACKET) begin
                do_fill  = 1'b1;
                v        = '0;
                slot_bad = 1'b1;
            end else begin
                do_retry  = 1'b1;
                nak_retry = (ph == PH_START);
            end
        end else if (ph == PH_PACKET) begin
            do_fill = 1'b1;
        end else if (ph == PH_START) begin
            if (b == C_SOH) begin
                open_packet();
            end else if (b == C_CAN) begin
                r.finished   = 1'b1;
                r.end_status = ST_CANCELLED;
                ph           = PH_IDLE;
            end else begin
                do_retry  = 1'b1;
                nak_retry = 1'b1;
            end
        end else begin
            if (b == C_SOH) begin
                retries = '0;
                open_packet();
            end else if (b == C_EOT) begin
                retries      = '0;
                r.send_valid = 1'b1;
                r.send_byte  = C_ACK;
                r.finished   = 1'b1;
                r.end_status = last_rej ? ST_REJECTED : ST_SUCCESS;
                ph           = PH_IDLE;
            end else begin
                do_retry = 1'b1;
            end
        end

        if (do_fill) begin
            tick_count = '0;
            if (slot == 0) begin
                got_blk = v;
            end else if (slot == 1) begin
                got_cmp = v;
            end else if (slot < BLOCK_BYTES + 2) begin
                sum_acc      = sum_acc + v;
                r.data_valid = 1'b1;
                r.data_byte  = v;
                r.data_index = 7'(slot - 2);
            end else begin
                ok = !slot_bad && got_blk == exp_block && got_cmp == ~exp_block
                     && sum_acc == v;
                r.verdict_valid = 1'b1;
                r.send_valid    = 1'b1;
                ph              = PH_BETWEEN;
                if (ok) begin
                    r.packet_accepted = 1'b1;
                    r.send_byte       = C_ACK;
                    retries           = '0;
                    exp_block         = exp_block + 8'd1;
                    last_rej          = 1'b0;
                end else begin
                    r.send_byte = C_NAK;
                    last_rej    = 1'b1;
                    do_retry    = 1'b1;
                end
            end
            slot = slot + 1;
        end

        if (do_retry) begin
            retries    = retries + 8'd1;
            tick_count = '0;
            if (retries >= lim_retry) begin
                r.finished   = 1'b1;
                r.end_status = ST_RETRIES;
                ph           = PH_IDLE;
            end else if (nak_retry) begin
                r.send_valid = 1'b1;
                r.send_byte  = C_NAK;
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // random byte that is neither SOH nor the other given control character
    function automatic logic [7:0] pick_junk(input logic [7:0] other);
        logic [7:0] v;
        v = pick_data();
        while (v == C_SOH || v == other) v = pick_data();
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers and result check
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.opcode  <= op;
        item_if.rx_byte <= b;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        if (op == OP_START || (op != OP_NONE && ph != PH_IDLE)) live_items++;
        due_results.push_back(advance_receiver(op, b));
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, pick_data());
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_RETRY_LIMIT:   lim_retry = val[7:0];
            CFG_START_TIMEOUT: lim_start = val;
            CFG_BYTE_TIMEOUT:  lim_byte  = val;
            default: ;
        endcase
    endtask

    initial begin : result_sink
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                result_if.ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (due_results.size() == 0) begin
                $error("result item arrived with nothing due");
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("send_valid", want.send_valid, result_if.send_valid);
                check_field("send_byte", want.send_byte, result_if.send_byte);
                check_field("data_valid", want.data_valid, result_if.data_valid);
                check_field("data_byte", want.data_byte, result_if.data_byte);
                check_field("data_index", want.data_index, result_if.data_index);
                check_field("verdict_valid", want.verdict_valid, result_if.verdict_valid);
                check_field("packet_accepted", want.packet_accepted,
                            result_if.packet_accepted);
                check_field("finished", want.finished, result_if.finished);
                check_field("end_status", want.end_status, result_if.end_status);
            end
        end
    end

    // watchdog: cycles in a row with no handshake on either channel
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    initial begin : watchdog
        wait (stall_count >= STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------------
    task automatic send_packet(input t_pkt_fault fault);
        logic [7:0] blk;
        logic [7:0] chk;
        logic [7:0] d;
        int         hole;
        int         stop_at;
        blk     = exp_block;
        chk     = '0;
        hole    = $urandom_range(0, BLOCK_BYTES + 2);
        stop_at = $urandom_range(0, BLOCK_BYTES + 1);
        if (fault == FLT_BLOCK) blk = blk + 8'($urandom_range(1, 255));
        send_item(OP_BYTE, C_SOH);
        for (int s = 0; s < BLOCK_BYTES + 3; s++) begin
            if (fault == FLT_ABORT && s == stop_at) begin
                // restart in the middle of a packet
                send_item(OP_START, pick_data());
                return;
            end
            // ticks short of a timeout only count
            if (lim_byte != 0 && lim_byte <= 4 && $urandom_range(0, 15) == 0)
                send_ticks(lim_byte - 1);
            if (fault == FLT_TIMEOUT && s == hole) begin
                send_ticks(lim_byte);
                continue;
            end
            if (s == 0)
                d = blk;
            else if (s == 1)
                d = (fault == FLT_CMP) ? blk ^ 8'($urandom_range(1, 255)) : ~blk;
            else if (s < BLOCK_BYTES + 2) begin
                d   = pick_data();
                chk = chk + d;
            end else
                d = (fault == FLT_SUM) ? chk + 8'($urandom_range(1, 255)) : chk;
            send_item(OP_BYTE, d);
        end
    endtask

    task automatic run_transfer();
        int         npk;
        t_pkt_fault fault;
        send_item(OP_START, pick_data());
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0)
                send_item(OP_BYTE, pick_junk(C_CAN));
            else if (lim_start <= 8)
                send_ticks(lim_start);
            else
                send_ticks($urandom_range(1, 3));
        end
        if ($urandom_range(0, 11) == 0) send_item(OP_BYTE, C_CAN);
        npk = $urandom_range(1, 3);
        for (int p = 0; p < npk && ph != PH_IDLE; p++) begin
            if (ph == PH_BETWEEN && $urandom_range(0, 4) == 0) begin
                if (lim_byte <= 8 && $urandom_range(0, 1) == 0)
                    send_ticks(lim_byte);
                else
                    send_item(OP_BYTE, pick_junk(C_EOT));
            end
            case ($urandom_range(0, 9))
                0: fault = FLT_SUM;
                1: fault = FLT_BLOCK;
                2: fault = FLT_CMP;
                3: fault = (lim_byte <= 8) ? FLT_TIMEOUT : FLT_SUM;
                4: fault = FLT_ABORT;
                default: fault = FLT_NONE;
            endcase
            if (ph != PH_IDLE) send_packet(fault);
        end
        if (ph != PH_IDLE && $urandom_range(0, 7) != 0) send_item(OP_BYTE, C_EOT);
    endtask

    task automatic pick_settings();
        case ($urandom_range(0, 3))
            0: write_reg(CFG_RETRY_LIMIT, 16'd1);
            1: write_reg(CFG_RETRY_LIMIT, 16'd255);
            default: write_reg(CFG_RETRY_LIMIT, 16'($urandom_range(2, 6)));
        endcase
        case ($urandom_range(0, 3))
            0: write_reg(CFG_START_TIMEOUT, 16'd65535);
            default: write_reg(CFG_START_TIMEOUT, 16'($urandom_range(1, 4)));
        endcase
        case ($urandom_range(0, 4))
            0: write_reg(CFG_BYTE_TIMEOUT, 16'd65535);
            1: write_reg(CFG_BYTE_TIMEOUT, 16'($urandom_range(9, 40000)));
            default: write_reg(CFG_BYTE_TIMEOUT, 16'($urandom_range(1, 5)));
        endcase
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_start_wait();
        // nothing but a start does anything while idle
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'hA5);
        send_item(OP_NONE, 8'h5A);
        send_item(OP_START, 8'h00);
        send_item(OP_NONE, 8'hFF);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, C_EOT);
        send_item(OP_BYTE, C_CAN);
        // start timeouts run out the retries
        write_reg(CFG_RETRY_LIMIT, 16'd2);
        write_reg(CFG_START_TIMEOUT, 16'd1);
        send_item(OP_START, 8'hFF);
        send_ticks(2);
        // zero timeout: every tick expires
        write_reg(CFG_START_TIMEOUT, 16'd0);
        send_item(OP_START, 8'h00);
        send_ticks(1);
        write_reg(CFG_RETRY_LIMIT, 16'd255);
        write_reg(CFG_START_TIMEOUT, 16'd65535);
        write_reg(CFG_BYTE_TIMEOUT, 16'd1);
        send_item(OP_START, 8'h81);
        send_ticks(3);
        send_item(OP_BYTE, C_SOH);
        send_ticks(2);
        send_item(OP_START, 8'h7E);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_BYTE_TIMEOUT, 16'd2000);
        hold_cycles = 80;
        send_item(OP_START, pick_data());
        send_item(OP_BYTE, C_SOH);
        repeat (20) send_item(OP_BYTE, pick_data());
    endtask

    task automatic test_random_transfers();
        while (live_items < 650) begin
            if ($urandom_range(0, 2) == 0) pick_settings();
            run_transfer();
        end
    endtask

    task automatic test_quiet_tail();
        write_reg(CFG_RETRY_LIMIT, 16'd10);
        write_reg(CFG_START_TIMEOUT, 16'd2);
        write_reg(CFG_BYTE_TIMEOUT, 16'd3);
        quiet = 1'b1;
        send_item(OP_START, pick_data());
        send_packet(FLT_NONE);
        send_item(OP_BYTE, C_EOT);
        // EOT after a rejected packet ends with its own status
        send_item(OP_START, pick_data());
        send_packet(FLT_SUM);
        send_item(OP_BYTE, C_EOT);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        item_if.valid   = 1'b0;
        item_if.opcode  = '0;
        item_if.rx_byte = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_start_wait();
        test_backpressure();
        test_random_transfers();
        test_quiet_tail();

        drain_results();
        if (errors == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
